// ===== hw/rtl/dmlh_pkg.sv =====
// dmlh_pkg: shared widths, constants and state codes of the line hull block
// no dependencies

package dmlh_pkg;

    localparam int DEF_MAX_LINES = 64;
    localparam int COEF_W        = 32;
    localparam int OPER_W        = COEF_W + 1;
    localparam int PROD_W        = 2 * OPER_W;
    localparam int VALUE_W       = 64;
    localparam int TOTAL_W       = 7;
    localparam int ENTRY_W       = 2 * COEF_W;

    // envelope value reported for an empty table, minus (9e18 + 5)
    localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = 64'sh831993AF1D7BFFFB;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [23:0] {
        S_IDLE       = 24'h000001,
        S_SCAN_RD    = 24'h000002,
        S_SCAN_CHK   = 24'h000004,
        S_FULL_CHK   = 24'h000008,
        S_MOVE       = 24'h000010,
        S_INS_WR     = 24'h000020,
        S_MID_TEST   = 24'h000040,
        S_LEFT_TEST  = 24'h000080,
        S_RIGHT_TEST = 24'h000100,
        S_LD0        = 24'h000200,
        S_LD1        = 24'h000400,
        S_LD2        = 24'h000800,
        S_LD3        = 24'h001000,
        S_DIFF       = 24'h002000,
        S_MUL_A      = 24'h004000,
        S_MUL_B      = 24'h008000,
        S_MUL_C      = 24'h010000,
        S_Q_TEST     = 24'h020000,
        S_Q_RD1      = 24'h040000,
        S_Q_RD2      = 24'h080000,
        S_Q_EV       = 24'h100000,
        S_Q_F1       = 24'h200000,
        S_Q_F2       = 24'h400000,
        S_DONE       = 24'h800000
    } state_t;

    // which pruning test a redundancy check belongs to
    typedef enum logic [2:0] {
        CTX_MID   = 3'b001,
        CTX_LEFT  = 3'b010,
        CTX_RIGHT = 3'b100
    } ctx_t;

endpackage

// ===== hw/rtl/dmlh_ram.sv =====
// dmlh_ram: generic single-write, single-read ram with registered read data
// no dependencies

module dmlh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/dmlh_mul.sv =====
// dmlh_mul: signed 33 x 33 multiplier with registered product
// depends on dmlh_pkg

module dmlh_mul
    import dmlh_pkg::*;
(
    input  logic                     clk,
    input  logic signed [OPER_W-1:0] a,
    input  logic signed [OPER_W-1:0] b,
    output logic signed [PROD_W-1:0] prod
);

    // one multiply per cycle, product ready in the next cycle
    always_ff @(posedge clk)
    begin
        prod <= a * b;
    end

endmodule

// ===== hw/rtl/dynamic_max_line_hull.sv =====
// dynamic_max_line_hull: upper envelope of lines kept sorted by slope in a ram
// depends on dmlh_pkg, dmlh_ram, dmlh_mul
//
//   channel   signals                                   direction
//   in        in_valid, in_stall, op, slope,            into block
//             intercept, query_x
//   out       out_valid, out_stall, max_value,          out of block
//             hull_empty, table_full, line_total
//
// one item is worked on at a time; the next is accepted once the sequencer
// is back in idle, even while the previous result waits in the output register.
// add: stored lines are scanned up to the slope position, then lines are
// shifted one by one for each insert or erase (ram port bound), plus
// redundancy tests through the shared multiplier.
// query: binary search, two ram reads and two multiplies per step.
// reset empties the table at once (line count to zero), no clearing pass.

module dynamic_max_line_hull
    import dmlh_pkg::*;
#(
    parameter int MAX_LINES = DEF_MAX_LINES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      op,
    input  logic signed [COEF_W-1:0]  slope,
    input  logic signed [COEF_W-1:0]  intercept,
    input  logic signed [COEF_W-1:0]  query_x,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] max_value,
    output logic                      hull_empty,
    output logic                      table_full,
    output logic [TOTAL_W-1:0]        line_total
);

    localparam int AW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);

    // control state
    state_t         state_reg, state_next;
    state_t         ret_reg, ret_next;
    ctx_t           ctx_reg, ctx_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  mv_src_reg, mv_src_next;
    logic [CW-1:0]  mv_left_reg, mv_left_next;
    logic           mv_up_reg, mv_up_next;
    logic           mv_pend_reg, mv_pend_next;
    logic           out_valid_reg, out_valid_next;

    // working payload
    logic [AW-1:0]              wr_addr_reg, wr_addr_next;
    logic [CW-1:0]              scan_reg, scan_next;
    logic [CW-1:0]              p_reg, p_next;
    logic [CW-1:0]              it_reg, it_next;
    logic [CW-1:0]              i0_reg, i0_next;
    logic [CW-1:0]              i1_reg, i1_next;
    logic [CW-1:0]              i2_reg, i2_next;
    logic [CW-1:0]              lo_reg, lo_next;
    logic [CW-1:0]              hi_reg, hi_next;
    logic [CW-1:0]              mid_reg, mid_next;
    logic signed [COEF_W-1:0]   new_m_reg, new_m_next;
    logic signed [COEF_W-1:0]   new_b_reg, new_b_next;
    logic signed [COEF_W-1:0]   qx_reg, qx_next;
    logic [ENTRY_W-1:0]         la_reg, la_next;
    logic [ENTRY_W-1:0]         lb_reg, lb_next;
    logic [ENTRY_W-1:0]         lc_reg, lc_next;
    logic signed [OPER_W-1:0]   da_reg, da_next;
    logic signed [OPER_W-1:0]   dc_reg, dc_next;
    logic signed [OPER_W-1:0]   dd_reg, dd_next;
    logic signed [OPER_W-1:0]   de_reg, de_next;
    logic signed [PROD_W-1:0]   p1_reg, p1_next;
    logic signed [COEF_W-1:0]   bm_reg, bm_next;
    logic signed [COEF_W-1:0]   b1_reg, b1_next;
    logic signed [VALUE_W-1:0]  ev0_reg, ev0_next;
    logic signed [VALUE_W-1:0]  res_value_reg, res_value_next;
    logic                       res_empty_reg, res_empty_next;
    logic                       res_full_reg, res_full_next;
    logic signed [VALUE_W-1:0]  out_value_reg, out_value_next;
    logic                       out_empty_reg, out_empty_next;
    logic                       out_full_reg, out_full_next;
    logic [TOTAL_W-1:0]         out_total_reg, out_total_next;

    // ram and multiplier hookup
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [ENTRY_W-1:0]        ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [ENTRY_W-1:0]        ram_rdata;
    logic signed [OPER_W-1:0]  mul_a;
    logic signed [OPER_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  mul_out;

    logic signed [COEF_W-1:0]  rd_m;
    logic signed [COEF_W-1:0]  rd_b;
    logic                      out_free;

    assign rd_m     = ram_rdata[ENTRY_W-1:COEF_W];
    assign rd_b     = ram_rdata[COEF_W-1:0];
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    dmlh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LINES)
    ) u_lines (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    dmlh_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_out)
    );

    // sequencer
    always_comb
    begin
        logic               erase_go;
        logic [CW-1:0]      erase_pos;
        state_t             erase_ret;
        logic [CW:0]        it_p1;
        logic [CW:0]        it_p2;
        logic [CW:0]        lohi_sum;
        logic signed [VALUE_W-1:0] ev1;

        erase_go  = 1'b0;
        erase_pos = '0;
        erase_ret = S_DONE;
        it_p1     = {1'b0, it_reg} + (CW+1)'(1);
        it_p2     = {1'b0, it_reg} + (CW+1)'(2);
        lohi_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
        ev1       = mul_out[VALUE_W-1:0] + VALUE_W'(b1_reg);

        state_next     = state_reg;
        ret_next       = ret_reg;
        ctx_next       = ctx_reg;
        count_next     = count_reg;
        mv_src_next    = mv_src_reg;
        mv_left_next   = mv_left_reg;
        mv_up_next     = mv_up_reg;
        mv_pend_next   = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        wr_addr_next   = wr_addr_reg;
        scan_next      = scan_reg;
        p_next         = p_reg;
        it_next        = it_reg;
        i0_next        = i0_reg;
        i1_next        = i1_reg;
        i2_next        = i2_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        new_m_next     = new_m_reg;
        new_b_next     = new_b_reg;
        qx_next        = qx_reg;
        la_next        = la_reg;
        lb_next        = lb_reg;
        lc_next        = lc_reg;
        da_next        = da_reg;
        dc_next        = dc_reg;
        dd_next        = dd_reg;
        de_next        = de_reg;
        p1_next        = p1_reg;
        bm_next        = bm_reg;
        b1_next        = b1_reg;
        ev0_next       = ev0_reg;
        res_value_next = res_value_reg;
        res_empty_next = res_empty_reg;
        res_full_next  = res_full_reg;
        out_value_next = out_value_reg;
        out_empty_next = out_empty_reg;
        out_full_next  = out_full_reg;
        out_total_next = out_total_reg;

        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = '0;
        mul_a     = '0;
        mul_b     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    new_m_next     = slope;
                    new_b_next     = intercept;
                    qx_next        = query_x;
                    res_value_next = '0;
                    res_empty_next = 1'b0;
                    res_full_next  = 1'b0;
                    scan_next      = '0;
                    lo_next        = '0;
                    hi_next        = count_reg - CW'(1);
                    if (op == OP_ADD)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else if (count_reg == '0)
                    begin
                        res_value_next = EMPTY_VALUE;
                        res_empty_next = 1'b1;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        state_next = S_Q_TEST;
                    end
                end
            end

            // linear scan for the first slope not below the new one
            S_SCAN_RD:
            begin
                ram_raddr = scan_reg[AW-1:0];
                if (scan_reg == count_reg)
                begin
                    p_next     = scan_reg;
                    state_next = S_FULL_CHK;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                if (rd_m < new_m_reg)
                begin
                    scan_next  = scan_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    p_next = scan_reg;
                    if (rd_m == new_m_reg)
                    begin
                        if (rd_b < new_b_reg)
                        begin
                            erase_go  = 1'b1;
                            erase_pos = scan_reg;
                            erase_ret = S_FULL_CHK;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        state_next = S_FULL_CHK;
                    end
                end
            end

            // flag a full table, else open a slot at the slope position
            S_FULL_CHK:
            begin
                if (count_reg >= CW'(MAX_LINES))
                begin
                    res_full_next = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    mv_src_next  = count_reg - CW'(1);
                    mv_left_next = count_reg - p_reg;
                    mv_up_next   = 1'b1;
                    ret_next     = S_INS_WR;
                    state_next   = S_MOVE;
                end
            end

            // streaming copy, read one entry while writing the previous one
            S_MOVE:
            begin
                ram_raddr = mv_src_reg[AW-1:0];
                if (mv_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (mv_left_reg != '0)
                begin
                    mv_pend_next = 1'b1;
                    mv_left_next = mv_left_reg - CW'(1);
                    if (mv_up_reg)
                    begin
                        wr_addr_next = AW'(mv_src_reg + CW'(1));
                        mv_src_next  = mv_src_reg - CW'(1);
                    end
                    else
                    begin
                        wr_addr_next = AW'(mv_src_reg - CW'(1));
                        mv_src_next  = mv_src_reg + CW'(1);
                    end
                end
                else if (!mv_pend_reg)
                begin
                    state_next = ret_reg;
                end
            end

            S_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = p_reg[AW-1:0];
                ram_wdata  = {new_m_reg, new_b_reg};
                count_next = count_reg + CW'(1);
                it_next    = p_reg;
                state_next = S_MID_TEST;
            end

            // new line under its two neighbors
            S_MID_TEST:
            begin
                if (it_reg != '0 && it_p1 < {1'b0, count_reg})
                begin
                    i0_next    = it_reg - CW'(1);
                    i1_next    = it_reg;
                    i2_next    = CW'(it_p1);
                    ctx_next   = CTX_MID;
                    state_next = S_LD0;
                end
                else
                begin
                    state_next = S_LEFT_TEST;
                end
            end

            S_LEFT_TEST:
            begin
                if (it_reg >= CW'(2))
                begin
                    i0_next    = it_reg - CW'(2);
                    i1_next    = it_reg - CW'(1);
                    i2_next    = it_reg;
                    ctx_next   = CTX_LEFT;
                    state_next = S_LD0;
                end
                else
                begin
                    state_next = S_RIGHT_TEST;
                end
            end

            S_RIGHT_TEST:
            begin
                if (it_p2 < {1'b0, count_reg})
                begin
                    i0_next    = it_reg;
                    i1_next    = CW'(it_p1);
                    i2_next    = CW'(it_p2);
                    ctx_next   = CTX_RIGHT;
                    state_next = S_LD0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // fetch the three lines of a redundancy test
            S_LD0:
            begin
                ram_raddr  = i0_reg[AW-1:0];
                state_next = S_LD1;
            end

            S_LD1:
            begin
                ram_raddr  = i1_reg[AW-1:0];
                la_next    = ram_rdata;
                state_next = S_LD2;
            end

            S_LD2:
            begin
                ram_raddr  = i2_reg[AW-1:0];
                lb_next    = ram_rdata;
                state_next = S_LD3;
            end

            S_LD3:
            begin
                lc_next    = ram_rdata;
                state_next = S_DIFF;
            end

            S_DIFF:
            begin
                da_next = $signed({la_reg[COEF_W-1], la_reg[COEF_W-1:0]})
                        - $signed({lc_reg[COEF_W-1], lc_reg[COEF_W-1:0]});
                dc_next = $signed({lb_reg[ENTRY_W-1], lb_reg[ENTRY_W-1:COEF_W]})
                        - $signed({la_reg[ENTRY_W-1], la_reg[ENTRY_W-1:COEF_W]});
                dd_next = $signed({la_reg[COEF_W-1], la_reg[COEF_W-1:0]})
                        - $signed({lb_reg[COEF_W-1], lb_reg[COEF_W-1:0]});
                de_next = $signed({lc_reg[ENTRY_W-1], lc_reg[ENTRY_W-1:COEF_W]})
                        - $signed({la_reg[ENTRY_W-1], la_reg[ENTRY_W-1:COEF_W]});
                state_next = S_MUL_A;
            end

            S_MUL_A:
            begin
                mul_a      = da_reg;
                mul_b      = dc_reg;
                state_next = S_MUL_B;
            end

            S_MUL_B:
            begin
                mul_a      = dd_reg;
                mul_b      = de_reg;
                p1_next    = mul_out;
                state_next = S_MUL_C;
            end

            // middle line redundant when (bi-bk)(mj-mi) <= (bi-bj)(mk-mi)
            S_MUL_C:
            begin
                unique case (ctx_reg)
                    CTX_MID:
                    begin
                        if (p1_reg <= mul_out)
                        begin
                            erase_go  = 1'b1;
                            erase_pos = it_reg;
                            erase_ret = S_DONE;
                        end
                        else
                        begin
                            state_next = S_LEFT_TEST;
                        end
                    end
                    CTX_LEFT:
                    begin
                        if (p1_reg <= mul_out)
                        begin
                            erase_go  = 1'b1;
                            erase_pos = it_reg - CW'(1);
                            erase_ret = S_LEFT_TEST;
                            it_next   = it_reg - CW'(1);
                        end
                        else
                        begin
                            state_next = S_RIGHT_TEST;
                        end
                    end
                    CTX_RIGHT:
                    begin
                        if (p1_reg <= mul_out)
                        begin
                            erase_go  = 1'b1;
                            erase_pos = CW'(it_p1);
                            erase_ret = S_RIGHT_TEST;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // binary search over adjacent lines
            S_Q_TEST:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = lohi_sum[CW:1];
                    ram_raddr  = AW'(lohi_sum[CW:1]);
                    state_next = S_Q_RD1;
                end
                else
                begin
                    ram_raddr  = lo_reg[AW-1:0];
                    state_next = S_Q_F1;
                end
            end

            S_Q_RD1:
            begin
                ram_raddr  = AW'(mid_reg + CW'(1));
                mul_a      = {rd_m[COEF_W-1], rd_m};
                mul_b      = {qx_reg[COEF_W-1], qx_reg};
                bm_next    = rd_b;
                state_next = S_Q_RD2;
            end

            S_Q_RD2:
            begin
                mul_a      = {rd_m[COEF_W-1], rd_m};
                mul_b      = {qx_reg[COEF_W-1], qx_reg};
                b1_next    = rd_b;
                ev0_next   = mul_out[VALUE_W-1:0] + VALUE_W'(bm_reg);
                state_next = S_Q_EV;
            end

            S_Q_EV:
            begin
                if (ev0_reg >= ev1)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + CW'(1);
                end
                state_next = S_Q_TEST;
            end

            S_Q_F1:
            begin
                mul_a      = {rd_m[COEF_W-1], rd_m};
                mul_b      = {qx_reg[COEF_W-1], qx_reg};
                bm_next    = rd_b;
                state_next = S_Q_F2;
            end

            S_Q_F2:
            begin
                res_value_next = mul_out[VALUE_W-1:0] + VALUE_W'(bm_reg);
                state_next     = S_DONE;
            end

            // hand the item's result to the output register
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_empty_next = res_empty_reg;
                    out_full_next  = res_full_reg;
                    out_total_next = TOTAL_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // erase of one entry: shift the tail down by one
        if (erase_go)
        begin
            mv_src_next  = erase_pos + CW'(1);
            mv_left_next = count_reg - erase_pos - CW'(1);
            mv_up_next   = 1'b0;
            count_next   = count_reg - CW'(1);
            ret_next     = erase_ret;
            state_next   = S_MOVE;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            ctx_reg       <= CTX_MID;
            count_reg     <= '0;
            mv_src_reg    <= '0;
            mv_left_reg   <= '0;
            mv_up_reg     <= 1'b0;
            mv_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            ctx_reg       <= ctx_next;
            count_reg     <= count_next;
            mv_src_reg    <= mv_src_next;
            mv_left_reg   <= mv_left_next;
            mv_up_reg     <= mv_up_next;
            mv_pend_reg   <= mv_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        wr_addr_reg   <= wr_addr_next;
        scan_reg      <= scan_next;
        p_reg         <= p_next;
        it_reg        <= it_next;
        i0_reg        <= i0_next;
        i1_reg        <= i1_next;
        i2_reg        <= i2_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        new_m_reg     <= new_m_next;
        new_b_reg     <= new_b_next;
        qx_reg        <= qx_next;
        la_reg        <= la_next;
        lb_reg        <= lb_next;
        lc_reg        <= lc_next;
        da_reg        <= da_next;
        dc_reg        <= dc_next;
        dd_reg        <= dd_next;
        de_reg        <= de_next;
        p1_reg        <= p1_next;
        bm_reg        <= bm_next;
        b1_reg        <= b1_next;
        ev0_reg       <= ev0_next;
        res_value_reg <= res_value_next;
        res_empty_reg <= res_empty_next;
        res_full_reg  <= res_full_next;
        out_value_reg <= out_value_next;
        out_empty_reg <= out_empty_next;
        out_full_reg  <= out_full_next;
        out_total_reg <= out_total_next;
    end

    // outputs
    assign out_valid  = out_valid_reg;
    assign max_value  = out_value_reg;
    assign hull_empty = out_empty_reg;
    assign table_full = out_full_reg;
    assign line_total = out_total_reg;

    // table never holds more lines than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LINES))
        else $error("line count above table depth");

    // the line count moves by one entry at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        (count_reg == $past(count_reg) + CW'(1) || count_reg == $past(count_reg) - CW'(1)))
        else $error("line count jumped");

    // a pending copy write only exists inside the move sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        mv_pend_reg |-> (state_reg == S_MOVE))
        else $error("copy write outside move");

    // a finished item with a free output slot is delivered next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not delivered");

endmodule
